### hdl/mrnt_pkg.sv
package mrnt_pkg;

	localparam int MAX_CITIES = 32;
	localparam int COORD_BITS = 16;

	localparam int IDX_W  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int CNT_W  = $clog2(MAX_CITIES + 1);
	localparam int DIST_W = COORD_BITS + 1;
	localparam int RUN_W  = 23;
	localparam int RAM_W  = 2 * COORD_BITS;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd2;

	localparam logic [1:0] MODE_ASC  = 2'd0;
	localparam logic [1:0] MODE_DESC = 2'd1;
	localparam logic [1:0] MODE_TOUR = 2'd2;

	typedef struct packed {
		logic signed [15:0] city_x;
		logic signed [15:0] city_y;
		logic               last_city;
	} city_t;

	typedef struct packed {
		logic [5:0]  rank;
		logic [4:0]  city_index;
		logic [16:0] leg_distance;
		logic [21:0] total_distance;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic load;
		logic start_run;
		logic issue;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic pipe_busy;
		logic out_full;
		logic run_last;
	} dp_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_WAIT
	} state_t;

endpackage

### hdl/manhattan_rank_and_nearest_tour_top.sv
// Cities load at one per cycle while idle; the item marked last_city starts a run.
// Each result takes one scan of the stored cities in the coordinate RAM (one read
// per cycle), two distance stages and a commit; the commit waits while output stalls.
// Reset clears the city count, visited marks, run state and configuration.
module manhattan_rank_and_nearest_tour_top import mrnt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  city_t                 in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	mrnt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_last (in_data.last_city),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	mrnt_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

### hdl/mrnt_ram.sv
module mrnt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/mrnt_ctrl.sv
module mrnt_ctrl import mrnt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start_run = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (status.issue_last) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (!status.pipe_busy && !status.out_full) begin
					cmd.commit = 1'b1;
					state_d    = status.run_last ? S_IDLE : S_SCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### hdl/mrnt_datapath.sv
module mrnt_datapath import mrnt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  city_t                 in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data
);

	logic [1:0]            mode_q;
	logic [COORD_BITS-1:0] org_x_q, org_y_q;
	logic [CNT_W-1:0]      cnt_q, k_q;
	logic [MAX_CITIES-1:0] visited_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [RUN_W-1:0]      total_q;
	logic [IDX_W-1:0]      addr_q;

	logic                  rd_v_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  v_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [COORD_BITS-1:0] x_s2, y_s2, adx_s2, ady_s2;

	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [DIST_W-1:0]     best_d_q;
	logic [COORD_BITS-1:0] best_x_q, best_y_q;

	logic                  out_valid_q;
	result_t               out_q;

	logic [RAM_W-1:0]      ram_rdata;
	logic                  ram_we;
	logic [COORD_BITS-1:0] ram_x, ram_y;
	logic [COORD_BITS:0]   dx, dy, ndx, ndy;
	logic [COORD_BITS-1:0] adx, ady;
	logic [DIST_W-1:0]     d_s2;
	logic                  better;
	logic                  tour, desc;
	logic [RUN_W-1:0]      new_total;

	assign tour = (mode_q == MODE_TOUR);
	assign desc = (mode_q == MODE_DESC);

	assign ram_we = cmd.load && (cnt_q < CNT_W'(MAX_CITIES));

	mrnt_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_CITIES)
	) u_coord_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata({in_data.city_x[COORD_BITS-1:0], in_data.city_y[COORD_BITS-1:0]}),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	assign ram_x = ram_rdata[RAM_W-1:COORD_BITS];
	assign ram_y = ram_rdata[COORD_BITS-1:0];

	assign dx  = {ram_x[COORD_BITS-1], ram_x} - {cur_x_q[COORD_BITS-1], cur_x_q};
	assign dy  = {ram_y[COORD_BITS-1], ram_y} - {cur_y_q[COORD_BITS-1], cur_y_q};
	assign ndx = -dx;
	assign ndy = -dy;
	assign adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
	assign ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

	assign d_s2   = {1'b0, adx_s2} + {1'b0, ady_s2};
	assign better = !found_q || (desc ? (d_s2 > best_d_q) : (d_s2 < best_d_q));

	assign new_total = total_q + RUN_W'(best_d_q);

	assign status.issue_last = (CNT_W'(addr_q) == cnt_q - CNT_W'(1));
	assign status.pipe_busy  = rd_v_s1 || v_s2;
	assign status.out_full   = out_valid_q && !out_ready;
	assign status.run_last   = (k_q + CNT_W'(1) == cnt_q);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ASC;
			org_x_q     <= '0;
			org_y_q     <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			visited_q   <= '0;
			total_q     <= '0;
			addr_q      <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:     mode_q  <= cfg_data[1:0];
					REG_ORIGIN_X: org_x_q <= cfg_data[COORD_BITS-1:0];
					REG_ORIGIN_Y: org_y_q <= cfg_data[COORD_BITS-1:0];
					default: ;
				endcase
			end

			if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			rd_v_s1 <= cmd.issue;
			v_s2    <= rd_v_s1 && !visited_q[rd_idx_s1];

			if (cmd.issue) begin
				addr_q <= addr_q + IDX_W'(1);
			end

			if (v_s2 && better) begin
				found_q <= 1'b1;
			end

			if (out_valid_q && out_ready && !cmd.commit) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.start_run) begin
				visited_q <= '0;
				total_q   <= '0;
				k_q       <= '0;
				addr_q    <= '0;
				found_q   <= 1'b0;
			end

			if (cmd.commit) begin
				visited_q[best_idx_q] <= 1'b1;
				if (tour) begin
					total_q <= new_total;
				end
				k_q         <= k_q + CNT_W'(1);
				addr_q      <= '0;
				found_q     <= 1'b0;
				out_valid_q <= 1'b1;
				if (status.run_last) begin
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		idx_s2    <= rd_idx_s1;
		x_s2      <= ram_x;
		y_s2      <= ram_y;
		adx_s2    <= adx;
		ady_s2    <= ady;

		if (v_s2 && better) begin
			best_idx_q <= idx_s2;
			best_d_q   <= d_s2;
			best_x_q   <= x_s2;
			best_y_q   <= y_s2;
		end

		if (cmd.start_run) begin
			cur_x_q <= org_x_q;
			cur_y_q <= org_y_q;
		end else if (cmd.commit && tour) begin
			cur_x_q <= best_x_q;
			cur_y_q <= best_y_q;
		end

		if (cmd.commit) begin
			out_q.rank           <= 6'(k_q + CNT_W'(1));
			out_q.city_index     <= 5'(best_idx_q);
			out_q.leg_distance   <= 17'(best_d_q);
			out_q.total_distance <= tour ? new_total[21:0] : 22'd0;
			out_q.last_result    <= status.run_last;
		end
	end

endmodule

### dv/manhattan_rank_and_nearest_tour_top_tb.sv
`timescale 1ns / 100ps

module manhattan_rank_and_nearest_tour_top_tb;
	import mrnt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
	localparam logic [1:0]           MODE_SPARE = 2'd3;
	localparam int SETTLE    = 40;
	localparam int LONG_HOLD = 400;
	localparam int N_STEPS   = 24;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	city_t                 in_data;
	logic                  out_valid;
	logic                  out_ready;
	result_t               out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	manhattan_rank_and_nearest_tour_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [1:0]         pred_mode;
	logic signed [15:0] pred_ox;
	logic signed [15:0] pred_oy;
	logic signed [15:0] xs [MAX_CITIES];
	logic signed [15:0] ys [MAX_CITIES];
	int                 stored;
	result_t            run_results [$];
	result_t            expected_results [$];

	int errors;
	int in_gap_pct;
	int rx_gap_pct;
	bit quiet;
	bit hold_req;

	typedef enum bit {ROW_CFG, ROW_CITY} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		city_t                 city;
		bit                    hand;
		result_t               hand_res;
	} step_row_t;

	step_row_t steps [N_STEPS] = '{
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sd0, 16'sd0, 1'b1},
			1'b1, '{6'd1, 5'd0, 17'd0, 22'd0, 1'b1}},
		'{ROW_CFG, REG_MODE, 16'(MODE_TOUR), '0, 1'b0, '0},
		'{ROW_CFG, REG_ORIGIN_X, 16'h7FFF, '0, 1'b0, '0},
		'{ROW_CFG, REG_ORIGIN_Y, 16'h7FFF, '0, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh8000, 16'sh8000, 1'b1},
			1'b1, '{6'd1, 5'd0, 17'd131070, 22'd131070, 1'b1}},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh7FFF, 16'sh8000, 1'b1}, 1'b0, '0},
		'{ROW_CFG, REG_ORIGIN_X, 16'h8000, '0, 1'b0, '0},
		'{ROW_CFG, REG_ORIGIN_Y, 16'h0000, '0, 1'b0, '0},
		'{ROW_CFG, REG_MODE, 16'(MODE_ASC), '0, 1'b0, '0},
		// three cities at equal distance, earliest must win
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh8000, 16'sd5, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh8005, 16'sd0, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh8000, -16'sd5, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh7FFF, 16'sh8000, 1'b1}, 1'b0, '0},
		'{ROW_CFG, REG_MODE, 16'(MODE_DESC), '0, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sd1, 16'sd1, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sd1, -16'sd1, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sh8000, 16'sd0, 1'b1}, 1'b0, '0},
		// write to a nonexistent register must be dropped
		'{ROW_CFG, REG_SPARE, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_CFG, REG_MODE, 16'(MODE_SPARE), '0, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{16'sd7, -16'sd7, 1'b0}, 1'b0, '0},
		'{ROW_CITY, REG_MODE, 16'd0, '{-16'sd7, 16'sd7, 1'b1}, 1'b0, '0}
	};

	function automatic int manhattan_dist(input int ax, input int ay, input int bx, input int by);
		int dx;
		int dy;
		dx = ax - bx;
		dy = ay - by;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		return dx + dy;
	endfunction

	// one run over the stored cities: sorted order or greedy tour
	function automatic void rank_cities();
		bit      taken [MAX_CITIES];
		int      cx;
		int      cy;
		int      best;
		int      bd;
		int      d;
		int      total;
		bit      tour;
		bit      desc;
		bit      found;
		result_t r;
		run_results.delete();
		taken = '{default: 1'b0};
		tour = (pred_mode == MODE_TOUR);
		desc = (pred_mode == MODE_DESC);
		cx = pred_ox;
		cy = pred_oy;
		total = 0;
		for (int k = 0; k < stored; k++) begin
			found = 1'b0;
			best = 0;
			bd = 0;
			for (int i = 0; i < stored; i++) begin
				if (!taken[i]) begin
					d = manhattan_dist(xs[i], ys[i], cx, cy);
					if (!found || (desc ? d > bd : d < bd)) begin
						found = 1'b1;
						best = i;
						bd = d;
					end
				end
			end
			taken[best] = 1'b1;
			if (tour) begin
				total = (total + bd) & 32'h7F_FFFF;
				cx = xs[best];
				cy = ys[best];
			end
			r.rank = 6'(k + 1);
			r.city_index = 5'(best);
			r.leg_distance = 17'(bd);
			r.total_distance = tour ? 22'(total) : 22'd0;
			r.last_result = (k + 1 == stored);
			run_results.push_back(r);
		end
		stored = 0;
	endfunction

	function automatic void load_city(input city_t c);
		run_results.delete();
		if (stored < MAX_CITIES) begin
			xs[stored] = c.city_x;
			ys[stored] = c.city_y;
			stored++;
		end
		if (c.last_city)
			rank_cities();
	endfunction

	function automatic logic [15:0] pick_coord(input int spread);
		case (spread)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 8)) - 16'd4;
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	task automatic send_city(input city_t c, input bit hand, input result_t hand_res);
		cfg_valid <= 1'b0;
		if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk); while (!in_ready);
		load_city(c);
		if (hand) begin
			expected_results.push_back(hand_res);
		end else begin
			foreach (run_results[i])
				expected_results.push_back(run_results[i]);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:     pred_mode = val[1:0];
			REG_ORIGIN_X: pred_ox = val;
			REG_ORIGIN_Y: pred_oy = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		#(2_000_000);
		$display("TB_ERROR");
		$finish;
	end

	// result side: checks every transfer, stalls in bursts
	initial begin
		result_t want;
		int      stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: rank=%0d city_index=%0d",
						out_data.rank, out_data.city_index);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.rank !== want.rank) begin
						$error("rank: expected %0d, got %0d", want.rank, out_data.rank);
						errors++;
					end
					if (out_data.city_index !== want.city_index) begin
						$error("city_index: expected %0d, got %0d",
							want.city_index, out_data.city_index);
						errors++;
					end
					if (out_data.leg_distance !== want.leg_distance) begin
						$error("leg_distance: expected %0d, got %0d",
							want.leg_distance, out_data.leg_distance);
						errors++;
					end
					if (out_data.total_distance !== want.total_distance) begin
						$error("total_distance: expected %0d, got %0d",
							want.total_distance, out_data.total_distance);
						errors++;
					end
					if (out_data.last_result !== want.last_result) begin
						$error("last_result: expected %0d, got %0d",
							want.last_result, out_data.last_result);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < rx_gap_pct) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		bit    prev_city;
		int    items;
		int    n;
		int    spread;
		city_t c;
		errors = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		in_gap_pct = 30;
		rx_gap_pct = 30;
		pred_mode = MODE_ASC;
		pred_ox = '0;
		pred_oy = '0;
		stored = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_city = 1'b1;
		foreach (steps[i]) begin
			if (steps[i].kind == ROW_CFG) begin
				if (prev_city)
					wait_idle();
				write_reg(steps[i].reg_idx, steps[i].reg_val);
				prev_city = 1'b0;
			end else begin
				send_city(steps[i].city, steps[i].hand, steps[i].hand_res);
				prev_city = 1'b1;
			end
		end

		items = 0;
		for (int b = 0; items < 115; b++) begin
			quiet = (items >= 85);
			in_gap_pct = $urandom_range(0, 2) * 25;
			rx_gap_pct = $urandom_range(0, 2) * 25;
			if (b % 3 == 0) begin
				wait_idle();
				write_reg(REG_MODE, 16'($urandom_range(0, 3)));
				write_reg(REG_ORIGIN_X, pick_coord($urandom_range(0, 2)));
				write_reg(REG_ORIGIN_Y, pick_coord($urandom_range(0, 2)));
			end
			// long output stall while the next batches keep coming
			if (b == 1)
				hold_req = 1'b1;
			// overfilled batches drop the cities past capacity
			n = (b == 2 || b == 5) ? MAX_CITIES + $urandom_range(1, 3) : $urandom_range(1, 8);
			spread = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) begin
				c.city_x = pick_coord(spread);
				c.city_y = pick_coord(spread);
				c.last_city = (i == n - 1);
				send_city(c, 1'b0, '0);
			end
			items += n;
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
